### sv/pfn_pkg.sv
// Shared constants and types for the Newell polygon face normal unit.
package pfn_pkg;
  localparam int COORD_WIDTH      = 16;
  localparam int ACC_WIDTH        = 48;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int TAG_W            = 16;
  localparam int OUT_W            = 16;
  localparam int MAG_W            = 30;
  localparam int SSQ_W            = 2 * MAG_W + 2;
  localparam int ROOT_W           = MAG_W + 1;
  localparam int NUM_W            = MAG_W + NORMAL_FRAC_BITS + 1;
  localparam int PROD_W           = 2 * (COORD_WIDTH + 1);
  localparam int Q_DEPTH          = 4;
  localparam int Q_AW             = 2;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] sx;
    logic signed [ACC_WIDTH-1:0] sy;
    logic signed [ACC_WIDTH-1:0] sz;
    logic [TAG_W-1:0]            tag;
    logic                        clip;
  } face_t;

  typedef struct packed {
    logic            valid;
    logic [Q_AW:0]   count;
  } q_stat_t;
endpackage

### sv/pfn_front.sv
// Edge front end: Newell cross terms and saturating running sums.
module pfn_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pfn_pkg::COORD_WIDTH-1:0] sx,
  input  logic signed [pfn_pkg::COORD_WIDTH-1:0] sy,
  input  logic signed [pfn_pkg::COORD_WIDTH-1:0] sz,
  input  logic signed [pfn_pkg::COORD_WIDTH-1:0] ex,
  input  logic signed [pfn_pkg::COORD_WIDTH-1:0] ey,
  input  logic signed [pfn_pkg::COORD_WIDTH-1:0] ez,
  input  logic [pfn_pkg::TAG_W-1:0]         tag,
  input  logic                              last,
  input  pfn_pkg::q_stat_t                  q_stat,
  output logic                              push,
  output pfn_pkg::face_t                    push_face
);
  import pfn_pkg::*;

  localparam int CW = COORD_WIDTH + 1;

  logic                       a_valid_r, a_last_r;
  logic [TAG_W-1:0]           a_tag_r;
  logic signed [PROD_W-1:0]   px_r, py_r, pz_r;
  logic signed [ACC_WIDTH-1:0] accx_r, accy_r, accz_r, accx_nxt, accy_nxt, accz_nxt;
  logic                       clip_r, clip_nxt;
  logic signed [CW-1:0]       ax, bx, ay, by, az, bz;
  logic [ACC_WIDTH:0]         rx, ry, rz;

  function automatic logic [ACC_WIDTH:0] sat_add(input logic signed [ACC_WIDTH-1:0] acc,
                                                 input logic signed [PROD_W-1:0] p);
    logic signed [ACC_WIDTH:0] s;
    logic [ACC_WIDTH-1:0]      v;
    s = {acc[ACC_WIDTH-1], acc} + (ACC_WIDTH+1)'(p);
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      v = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      return {1'b1, v};
    end
    return {1'b0, s[ACC_WIDTH-1:0]};
  endfunction

  assign in_ready = ({1'b0, q_stat.count} + (Q_AW+2)'(a_valid_r && a_last_r))
                    < (Q_AW+2)'(Q_DEPTH);

  always_comb begin
    ax = CW'(sy) + CW'(ey);
    bx = CW'(ez) - CW'(sz);
    ay = CW'(sz) + CW'(ez);
    by = CW'(ex) - CW'(sx);
    az = CW'(sx) + CW'(ex);
    bz = CW'(ey) - CW'(sy);
  end

  always_comb begin
    rx = sat_add(accx_r, px_r);
    ry = sat_add(accy_r, py_r);
    rz = sat_add(accz_r, pz_r);
    accx_nxt = accx_r;
    accy_nxt = accy_r;
    accz_nxt = accz_r;
    clip_nxt = clip_r;
    push = 1'b0;
    push_face.sx = rx[ACC_WIDTH-1:0];
    push_face.sy = ry[ACC_WIDTH-1:0];
    push_face.sz = rz[ACC_WIDTH-1:0];
    push_face.tag = a_tag_r;
    push_face.clip = clip_r | rx[ACC_WIDTH] | ry[ACC_WIDTH] | rz[ACC_WIDTH];
    if (a_valid_r) begin
      if (a_last_r) begin
        push = 1'b1;
        accx_nxt = '0;
        accy_nxt = '0;
        accz_nxt = '0;
        clip_nxt = 1'b0;
      end else begin
        accx_nxt = rx[ACC_WIDTH-1:0];
        accy_nxt = ry[ACC_WIDTH-1:0];
        accz_nxt = rz[ACC_WIDTH-1:0];
        clip_nxt = push_face.clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_last_r  <= 1'b0;
      accx_r    <= '0;
      accy_r    <= '0;
      accz_r    <= '0;
      clip_r    <= 1'b0;
    end else begin
      a_valid_r <= in_valid && in_ready;
      a_last_r  <= last;
      accx_r    <= accx_nxt;
      accy_r    <= accy_nxt;
      accz_r    <= accz_nxt;
      clip_r    <= clip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_tag_r <= tag;
    px_r    <= ax * bx;
    py_r    <= ay * by;
    pz_r    <= az * bz;
  end
endmodule

### sv/pfn_queue.sv
// Short face queue between the edge front end and the normalizer.
module pfn_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pfn_pkg::face_t    push_face,
  input  logic              pop,
  output pfn_pkg::q_stat_t  q_stat,
  output pfn_pkg::face_t    head
);
  import pfn_pkg::*;

  face_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, rptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign q_stat.valid = cnt_r != '0;
  assign q_stat.count = cnt_r;
  assign head = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_face;
  end
endmodule

### sv/pfn_back.sv
// Normalizer: scale, sum of squares, square root and divisions per face.
module pfn_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pfn_pkg::q_stat_t        q_stat,
  input  pfn_pkg::face_t          head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [pfn_pkg::OUT_W-1:0] nx,
  output logic [pfn_pkg::OUT_W-1:0] ny,
  output logic [pfn_pkg::OUT_W-1:0] nz,
  output logic [pfn_pkg::TAG_W-1:0] tag,
  output logic                    degen,
  output logic                    sat
);
  import pfn_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHIFT = 7'b0000010,
    S_SQ    = 7'b0000100,
    S_ROOT  = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t              state_r;
  logic [ACC_WIDTH-1:0] m_r [3];
  logic [2:0]          neg_r;
  logic [TAG_W-1:0]    tag_r;
  logic                clip_r, degen_r;
  logic [1:0]          idx_r;
  logic [STEP_W-1:0]   step_r;
  logic [2*MAG_W-1:0]  prod_r;
  logic [SSQ_W-1:0]    ssq_r, ssq_sum, n_r, r_r, bit_r;
  logic [SSQ_W:0]      trial;
  logic [ROOT_W-1:0]   len_r;
  logic [ROOT_W:0]     rem_r, rem_s;
  logic [NUM_W-1:0]    num_r, q_fin, q_c;
  logic [OUT_W-1:0]    res_r [3];
  logic                out_valid_r;
  logic [OUT_W-1:0]    nx_r, ny_r, nz_r;
  logic [TAG_W-1:0]    otag_r;
  logic                odegen_r, osat_r;
  logic [MAG_W-1:0]    msel;

  assign out_valid = out_valid_r;
  assign nx = nx_r;
  assign ny = ny_r;
  assign nz = nz_r;
  assign tag = otag_r;
  assign degen = odegen_r;
  assign sat = osat_r;
  assign pop = (state_r == S_IDLE) && q_stat.valid;

  assign msel    = (idx_r == 2'd3) ? '0 : m_r[idx_r][MAG_W-1:0];
  assign ssq_sum = ssq_r + SSQ_W'(prod_r);
  assign trial   = {1'b0, r_r} + {1'b0, bit_r};
  assign rem_s   = {rem_r[ROOT_W-1:0], num_r[NUM_W-1]};
  assign q_fin   = {num_r[NUM_W-2:0], rem_s >= {1'b0, len_r}};

  always_comb begin
    q_c = q_fin;
    if (neg_r[idx_r]) begin
      if (q_fin > NUM_W'(2 ** (OUT_W - 1))) q_c = NUM_W'(2 ** (OUT_W - 1));
    end else begin
      if (q_fin > NUM_W'(2 ** (OUT_W - 1) - 1)) q_c = NUM_W'(2 ** (OUT_W - 1) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_stat.valid) begin
            if (head.sx == '0 && head.sy == '0 && head.sz == '0) state_r <= S_OUT;
            else state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (((m_r[0] | m_r[1] | m_r[2]) >> MAG_W) == '0) state_r <= S_SQ;
        end
        S_SQ: begin
          if (idx_r == 2'd3) state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (step_r == STEP_W'(ROOT_W - 1)) state_r <= S_LOAD;
        end
        S_LOAD: state_r <= S_DIV;
        S_DIV: begin
          if (step_r == STEP_W'(NUM_W - 1)) state_r <= (idx_r == 2'd2) ? S_OUT : S_LOAD;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        neg_r   <= {head.sz[ACC_WIDTH-1], head.sy[ACC_WIDTH-1], head.sx[ACC_WIDTH-1]};
        m_r[0]  <= head.sx[ACC_WIDTH-1] ? -head.sx : head.sx;
        m_r[1]  <= head.sy[ACC_WIDTH-1] ? -head.sy : head.sy;
        m_r[2]  <= head.sz[ACC_WIDTH-1] ? -head.sz : head.sz;
        tag_r   <= head.tag;
        clip_r  <= head.clip;
        degen_r <= head.sx == '0 && head.sy == '0 && head.sz == '0;
        res_r[0] <= '0;
        res_r[1] <= '0;
        res_r[2] <= '0;
        idx_r   <= '0;
        ssq_r   <= '0;
        prod_r  <= '0;
      end
      S_SHIFT: begin
        if (((m_r[0] | m_r[1] | m_r[2]) >> MAG_W) != '0) begin
          m_r[0] <= m_r[0] >> 1;
          m_r[1] <= m_r[1] >> 1;
          m_r[2] <= m_r[2] >> 1;
        end
      end
      S_SQ: begin
        prod_r <= msel * msel;
        if (idx_r != 2'd0) ssq_r <= ssq_sum;
        idx_r <= idx_r + 1'b1;
        if (idx_r == 2'd3) begin
          n_r    <= ssq_sum;
          r_r    <= '0;
          bit_r  <= SSQ_W'(1) << (2 * (ROOT_W - 1));
          step_r <= '0;
        end
      end
      S_ROOT: begin
        if ({1'b0, n_r} >= trial) begin
          n_r <= n_r - trial[SSQ_W-1:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r + 1'b1;
        if ({1'b0, n_r} >= trial) len_r <= ROOT_W'((r_r >> 1) + bit_r);
        else len_r <= ROOT_W'(r_r >> 1);
        idx_r <= '0;
      end
      S_LOAD: begin
        num_r  <= ({NUM_W'(msel)} << NORMAL_FRAC_BITS) + NUM_W'(len_r >> 1);
        rem_r  <= '0;
        step_r <= '0;
      end
      S_DIV: begin
        if (rem_s >= {1'b0, len_r}) rem_r <= rem_s - {1'b0, len_r};
        else rem_r <= rem_s;
        num_r  <= q_fin;
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(NUM_W - 1)) begin
          res_r[idx_r] <= neg_r[idx_r] ? OUT_W'(0) - q_c[OUT_W-1:0] : q_c[OUT_W-1:0];
          idx_r <= idx_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          nx_r     <= res_r[0];
          ny_r     <= res_r[1];
          nz_r     <= res_r[2];
          otag_r   <= tag_r;
          odegen_r <= degen_r;
          osat_r   <= clip_r;
        end
      end
      default: ;
    endcase
  end
endmodule

### sv/polygon_face_normal_newell_top.sv
// Top level of the Newell polygon face normal unit.
// Edges: one item per cycle while in_tready is high; an edge's cross products are registered, then summed.
// Face result: after its last edge a face passes the shift loop (0 to 18 shifts), the sum of squares,
// the 31-step square root and three divisions; a zero sum goes straight to the output.
// The normalizer takes one face at a time; a four-entry face queue keeps edges flowing.
// Synchronous active-low reset clears the sums, the queue and the output valid flag.
module polygon_face_normal_newell_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // start_x, start_y, start_z, end_x, end_y, end_z, face_tag
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // normal_x, normal_y, normal_z, out_face_tag
  output logic [1:0]   out_tuser  // degenerate, saturated
);
  import pfn_pkg::*;

  q_stat_t          q_stat;
  face_t            push_face, head;
  logic             push, pop;
  logic [OUT_W-1:0] nx, ny, nz;
  logic [TAG_W-1:0] tag;
  logic             degen, sat;

  pfn_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .sx(in_tdata[15:0]), .sy(in_tdata[31:16]), .sz(in_tdata[47:32]),
    .ex(in_tdata[63:48]), .ey(in_tdata[79:64]), .ez(in_tdata[95:80]),
    .tag(in_tdata[111:96]), .last(in_tlast),
    .q_stat(q_stat), .push(push), .push_face(push_face)
  );

  pfn_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_face(push_face),
    .pop(pop), .q_stat(q_stat), .head(head)
  );

  pfn_back u_back (
    .clk(clk), .rst_n(rst_n), .q_stat(q_stat), .head(head), .pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .nx(nx), .ny(ny), .nz(nz), .tag(tag), .degen(degen), .sat(sat)
  );

  assign out_tdata = {tag, nz, ny, nx};
  assign out_tuser = {sat, degen};
endmodule
